### design/psb_pkg.sv
`default_nettype none
package psb_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_QUIET = 2'd2;

  localparam logic [7:0] MAGIC_BYTE = 8'hC0;
  localparam logic [7:0] RX_KIND_REQ = 8'h01;
  localparam logic [7:0] RX_KIND_ACK = 8'h02;
  localparam logic [3:0] MIN_LEN = 4'd5;

  localparam logic [1:0] TX_REQ = 2'd1;
  localparam logic [1:0] TX_ACK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  localparam logic OUT_BEACON = 1'b0;
  localparam logic OUT_STATUS = 1'b1;

  localparam logic [1:0] TRAIL_ACKS = 2'd3;

  localparam logic [1:0] CFG_OWN_INDEX = 2'd0;
  localparam logic [1:0] CFG_OWN_PHASE = 2'd1;
  localparam logic [1:0] CFG_WAIT_LIMIT = 2'd2;
  localparam logic [1:0] CFG_INTERVAL = 2'd3;

  localparam logic [15:0] RST_OWN_INDEX = 16'd0;
  localparam logic [7:0] RST_OWN_PHASE = 8'd0;
  localparam logic [31:0] RST_WAIT_LIMIT = 32'd10000;
  localparam logic [15:0] RST_INTERVAL = 16'd200;

  typedef enum logic [2:0] {
    CMD_REQ,
    CMD_TIMEOUT,
    CMD_MISMATCH,
    CMD_ACK3,
    CMD_ACK4
  } cmd_code_e;

  typedef struct packed {
    cmd_code_e code;
    logic [15:0] peer;
  } cmd_t;

  typedef struct packed {
    logic [15:0] own_index;
    logic [7:0] own_phase;
    logic [31:0] wait_limit;
    logic [15:0] interval;
  } cfg_t;

  typedef struct packed {
    logic out_kind;
    logic [1:0] tx_type;
    logic [7:0] tx_phase;
    logic [15:0] tx_index;
    logic [1:0] status;
    logic [15:0] peer_index;
    logic last;
  } res_t;

endpackage
`default_nettype wire

### design/peer_sync_barrier_handshake.sv
`default_nettype none
// Channel   Handshake             Payload
// in        in_valid_i/in_stall_o  op, rx_length, rx_magic, rx_kind, rx_phase, rx_index
// out       out_valid_o/out_stall_i out_kind, tx_type, tx_phase, tx_index, status,
//                                  peer_index, last
// cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item is classified in the cycle it is taken and queued at that edge; its first beat
// is popped from the queue into the output register, one beat per cycle unless stalled.
// A completing item gives 4 or 5 beats, every other item 1 or none; the beat sequencer
// of the back end sets the sustained rate. Two decoded items queue between the halves.
// Reset loads register defaults and closes any wait. Output stall holds the beat;
// input stall rises only while the queue is full.
module peer_sync_barrier_handshake (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic cfg_valid_i,
  output logic cfg_ready_o,
  input wire logic [1:0] cfg_index_i,
  input wire logic [31:0] cfg_data_i,
  input wire logic in_valid_i,
  output logic in_stall_o,
  input wire logic [1:0] op_i,
  input wire logic [3:0] rx_length_i,
  input wire logic [7:0] rx_magic_i,
  input wire logic [7:0] rx_kind_i,
  input wire logic [7:0] rx_phase_i,
  input wire logic [15:0] rx_index_i,
  output logic out_valid_o,
  input wire logic out_stall_i,
  output logic out_kind_o,
  output logic [1:0] tx_type_o,
  output logic [7:0] tx_phase_o,
  output logic [15:0] tx_index_o,
  output logic [1:0] status_o,
  output logic [15:0] peer_index_o,
  output logic last_o
);
  import psb_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_index <= RST_OWN_INDEX;
      cfg_q.own_phase <= RST_OWN_PHASE;
      cfg_q.wait_limit <= RST_WAIT_LIMIT;
      cfg_q.interval <= RST_INTERVAL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_INDEX: cfg_q.own_index <= cfg_data_i[15:0];
        CFG_OWN_PHASE: cfg_q.own_phase <= cfg_data_i[7:0];
        CFG_WAIT_LIMIT: cfg_q.wait_limit <= cfg_data_i;
        CFG_INTERVAL: cfg_q.interval <= cfg_data_i[15:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  psb_front u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i(op_i),
    .rx_length_i(rx_length_i),
    .rx_magic_i(rx_magic_i),
    .rx_kind_i(rx_kind_i),
    .rx_phase_i(rx_phase_i),
    .rx_index_i(rx_index_i),
    .push_o(push),
    .cmd_o(push_cmd),
    .full_i(full)
  );

  psb_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i(push_cmd),
    .full_o(full),
    .pop_i(pop),
    .cmd_o(pop_cmd),
    .empty_o(empty)
  );

  psb_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .cmd_i(pop_cmd),
    .empty_i(empty),
    .pop_o(pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o(res)
  );

  assign out_kind_o = res.out_kind;
  assign tx_type_o = res.tx_type;
  assign tx_phase_o = res.tx_phase;
  assign tx_index_o = res.tx_index;
  assign status_o = res.status;
  assign peer_index_o = res.peer_index;
  assign last_o = res.last;

endmodule
`default_nettype wire

### design/psb_front.sv
`default_nettype none
module psb_front (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire psb_pkg::cfg_t cfg_i,
  input wire logic in_valid_i,
  output logic in_stall_o,
  input wire logic [1:0] op_i,
  input wire logic [3:0] rx_length_i,
  input wire logic [7:0] rx_magic_i,
  input wire logic [7:0] rx_kind_i,
  input wire logic [7:0] rx_phase_i,
  input wire logic [15:0] rx_index_i,
  output logic push_o,
  output psb_pkg::cmd_t cmd_o,
  input wire logic full_i
);
  import psb_pkg::*;

  logic waiting_q, waiting_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic accept;
  logic frame_ok;
  logic [32:0] sum;
  logic [31:0] sat;

  assign in_stall_o = full_i;
  assign accept = in_valid_i && !full_i;

  assign frame_ok = (op_i == OP_FRAME) && (rx_length_i >= MIN_LEN) &&
                    (rx_magic_i == MAGIC_BYTE) && (rx_phase_i == cfg_i.own_phase);
  assign sum = {1'b0, elapsed_q} + {17'd0, cfg_i.interval};
  assign sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_comb begin
    waiting_d = waiting_q;
    elapsed_d = elapsed_q;
    push_o = 1'b0;
    cmd_o.code = CMD_REQ;
    cmd_o.peer = rx_index_i;
    if (accept) begin
      if (op_i == OP_START) begin
        elapsed_d = '0;
        push_o = 1'b1;
        if (cfg_i.wait_limit == 32'd0) begin
          waiting_d = 1'b0;
          cmd_o.code = CMD_TIMEOUT;
        end else begin
          waiting_d = 1'b1;
          cmd_o.code = CMD_REQ;
        end
      end else if (waiting_q && (op_i == OP_FRAME || op_i == OP_QUIET)) begin
        push_o = 1'b1;
        if (frame_ok && rx_index_i == cfg_i.own_index && rx_kind_i == RX_KIND_REQ) begin
          cmd_o.code = CMD_ACK4;
          waiting_d = 1'b0;
        end else if (frame_ok && rx_index_i == cfg_i.own_index &&
                     rx_kind_i == RX_KIND_ACK) begin
          cmd_o.code = CMD_ACK3;
          waiting_d = 1'b0;
        end else if (frame_ok && rx_index_i > cfg_i.own_index) begin
          cmd_o.code = CMD_MISMATCH;
          waiting_d = 1'b0;
        end else begin
          elapsed_d = sat;
          if (sat < cfg_i.wait_limit) begin
            cmd_o.code = CMD_REQ;
          end else begin
            cmd_o.code = CMD_TIMEOUT;
            waiting_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      elapsed_q <= '0;
    end else begin
      waiting_q <= waiting_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule
`default_nettype wire

### design/psb_queue.sv
`default_nettype none
module psb_queue (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic push_i,
  input wire psb_pkg::cmd_t cmd_i,
  output logic full_o,
  input wire logic pop_i,
  output psb_pkg::cmd_t cmd_o,
  output logic empty_o
);
  import psb_pkg::*;

  cmd_t mem_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### design/psb_back.sv
`default_nettype none
module psb_back (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire psb_pkg::cfg_t cfg_i,
  input wire psb_pkg::cmd_t cmd_i,
  input wire logic empty_i,
  output logic pop_o,
  output logic out_valid_o,
  input wire logic out_stall_i,
  output psb_pkg::res_t res_o
);
  import psb_pkg::*;

  logic busy_q, busy_d;
  logic [1:0] acks_q, acks_d;
  logic valid_q, valid_d;
  res_t res_q, res_d;
  res_t beacon_ack, stat_ok;
  logic advance;

  assign advance = !valid_q || !out_stall_i;
  assign pop_o = advance && !busy_q && !empty_i;
  assign out_valid_o = valid_q;
  assign res_o = res_q;

  always_comb begin
    beacon_ack = '{out_kind: OUT_BEACON, tx_type: TX_ACK, tx_phase: cfg_i.own_phase,
                   tx_index: cfg_i.own_index, status: ST_OK, peer_index: 16'd0,
                   last: 1'b0};
    stat_ok = '{out_kind: OUT_STATUS, tx_type: 2'd0, tx_phase: 8'd0, tx_index: 16'd0,
                status: ST_OK, peer_index: 16'd0, last: 1'b1};
  end

  always_comb begin
    busy_d = busy_q;
    acks_d = acks_q;
    valid_d = valid_q;
    res_d = res_q;
    if (advance) begin
      valid_d = busy_q || !empty_i;
      if (busy_q) begin
        if (acks_q != 2'd0) begin
          res_d = beacon_ack;
          acks_d = acks_q - 2'd1;
        end else begin
          res_d = stat_ok;
          busy_d = 1'b0;
        end
      end else if (!empty_i) begin
        unique case (cmd_i.code)
          CMD_REQ: begin
            res_d = beacon_ack;
            res_d.tx_type = TX_REQ;
            res_d.last = 1'b1;
          end
          CMD_TIMEOUT: begin
            res_d = stat_ok;
            res_d.status = ST_TIMEOUT;
          end
          CMD_MISMATCH: begin
            res_d = stat_ok;
            res_d.status = ST_MISMATCH;
            res_d.peer_index = cmd_i.peer;
          end
          CMD_ACK3: begin
            res_d = beacon_ack;
            busy_d = 1'b1;
            acks_d = TRAIL_ACKS - 2'd1;
          end
          CMD_ACK4: begin
            res_d = beacon_ack;
            busy_d = 1'b1;
            acks_d = TRAIL_ACKS;
          end
          default: begin
            res_d = stat_ok;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      acks_q <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      acks_q <= acks_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
`default_nettype wire
